### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MARS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MARS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mars_pkg.sv
// ----------------------------------------------------------------------------
// mars_pkg
// Types and constants shared by the address reference scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mars_pkg;

  localparam int unsigned PositionBits  = 22;
  localparam int unsigned PairWindowDef = 31;
  localparam int unsigned MaxReports    = 32;
  localparam int unsigned CntW          = $clog2(MaxReports + 1);

  // major opcodes, bits [31:26]
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpJal   = 6'h03;
  localparam logic [5:0] OpLui   = 6'h0F;

  typedef enum logic [1:0] {
    HIT_DIRECT = 2'd0,
    HIT_JAL    = 2'd1,
    HIT_PAIR   = 2'd2
  } mars_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_FINISH
  } mars_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_RETIRE,
    CELL_SHIFT,
    CELL_CLEAR
  } mars_cell_op_t;

  typedef struct packed {
    logic [31:0] code_word;
    logic        image_end;
  } mars_in_t;

  typedef struct packed {
    logic [1:0]              hit_kind;
    logic [PositionBits-1:0] hit_position;
    logic [31:0]             hit_word;
    logic [PositionBits-1:0] partner_position;
    logic [31:0]             partner_word;
    logic                    final_report;
  } mars_out_t;

  // one pending LUI slot
  typedef struct packed {
    logic                    valid;
    logic                    rep;
    logic [31:0]             word;
    logic [PositionBits-1:0] pos;
  } mars_entry_t;

  // ADDIU probe broadcast to every cell
  typedef struct packed {
    logic       scan;
    logic [4:0] rs;
    logic       imm_ok;
  } mars_probe_t;

endpackage

`default_nettype wire

### hdl/mips_address_reference_scanner.sv
// ----------------------------------------------------------------------------
// mips_address_reference_scanner
// Scans big-endian MIPS words for direct, JAL and LUI/ADDIU references to a
// configured target address.
// ----------------------------------------------------------------------------
// A word that completes no LUI/ADDIU pair is taken, and its direct or JAL
// hit, if any, appears in the output register on the next cycle. A word
// that completes one or more pairs passes through the scan, one full
// end-around rotation of the pending-LUI cell row past the report port,
// then the aging step; a rotation or aging step that has a report to give
// waits while the output side stalls, and no new word is taken until the
// aging step is done. Pending slots reset through per-cell valid bits, so
// no clearing pass follows reset. Write the target only while the block is idle.
`default_nettype none

module mips_address_reference_scanner #(
  parameter int unsigned PAIR_WINDOW = mars_pkg::PairWindowDef
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  mars_pkg::mars_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output mars_pkg::mars_out_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [31:0]          cfg_data
);
  import mars_pkg::*;

  localparam int unsigned StepW = (PAIR_WINDOW > 1) ? $clog2(PAIR_WINDOW) : 1;

  mars_state_t             state_r, state_nxt;
  logic [31:0]             target_r;
  logic [PositionBits-1:0] pos_r, pos_nxt;
  logic [StepW-1:0]        step_r, step_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic [31:0]             word_r, word_nxt;
  logic                    hit_r, hit_nxt;
  mars_kind_t              kind_r, kind_nxt;
  logic                    last_r, last_nxt;
  logic                    lui_r, lui_nxt;
  logic                    out_valid_r, out_valid_nxt;
  mars_out_t               out_data_r, out_data_nxt;

  logic [31:0]   code;
  logic [31:0]   jal_word;
  logic [16:0]   hi_adj;
  logic          is_direct, is_jal, is_lui;
  logic          out_free, in_take, emit_want, advance;
  mars_cell_op_t cell_op;
  mars_probe_t   probe;
  logic          wrap;
  mars_entry_t   head;
  mars_entry_t   oldest;
  logic          any_pair, rep_rest;

  assign code      = in_data.code_word;
  assign jal_word  = {OpJal, target_r[27:2]};
  assign hi_adj    = {1'b0, target_r[31:16]} + {16'b0, target_r[15]};
  assign is_direct = (code == target_r);
  assign is_jal    = (code == jal_word);
  assign is_lui    = (code[31:26] == OpLui) && ({1'b0, code[15:0]} == hi_adj);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign probe = '{scan:   in_take && (code[31:26] == OpAddiu),
                   rs:     code[25:21],
                   imm_ok: code[15:0] == target_r[15:0]};

  mars_chain #(
    .PAIR_WINDOW (PAIR_WINDOW)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (cell_op),
    .probe_i    (probe),
    .wrap_i     (wrap),
    .head_i     (head),
    .oldest_o   (oldest),
    .any_pair_o (any_pair),
    .rep_rest_o (rep_rest)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    hit_nxt       = hit_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    lui_nxt       = lui_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cell_op       = CELL_HOLD;
    wrap          = 1'b0;
    head          = '{valid: 1'b0, rep: 1'b0, word: word_r, pos: pos_r};
    emit_want     = 1'b0;
    advance       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        head = '{valid: is_lui && !is_direct && !is_jal, rep: 1'b0, word: code,
                 pos: pos_r};
        if (in_take) begin
          if (any_pair) begin
            // park the word, flag the pairs in place and start a rotation
            cell_op   = CELL_RETIRE;
            word_nxt  = code;
            hit_nxt   = is_direct || is_jal;
            kind_nxt  = is_direct ? HIT_DIRECT : HIT_JAL;
            last_nxt  = in_data.image_end;
            lui_nxt   = is_lui && !is_direct && !is_jal;
            step_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_ROTATE;
          end else begin
            cell_op = in_data.image_end ? CELL_CLEAR : CELL_SHIFT;
            pos_nxt = in_data.image_end ? '0 : pos_r + PositionBits'(1);
            if (is_direct || is_jal) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{hit_kind:         is_direct ? HIT_DIRECT : HIT_JAL,
                                hit_position:     pos_r,
                                hit_word:         code,
                                partner_position: '0,
                                partner_word:     '0,
                                final_report:     1'b1};
            end
          end
        end
      end

      ST_ROTATE: begin
        emit_want = oldest.rep && (cnt_r < CntW'(MaxReports));
        advance   = !emit_want || out_free;
        if (advance) begin
          cell_op = CELL_SHIFT;
          wrap    = 1'b1;
          if (emit_want) begin
            out_valid_nxt = 1'b1;
            cnt_nxt       = cnt_r + CntW'(1);
            out_data_nxt  = '{hit_kind:         HIT_PAIR,
                              hit_position:     oldest.pos,
                              hit_word:         oldest.word,
                              partner_position: pos_r,
                              partner_word:     word_r,
                              final_report:     (cnt_r == CntW'(MaxReports - 1)) ||
                                                (!rep_rest && !hit_r)};
          end
          if (step_r == StepW'(PAIR_WINDOW - 1)) begin
            state_nxt = ST_FINISH;
          end else begin
            step_nxt = step_r + StepW'(1);
          end
        end
      end

      ST_FINISH: begin
        head      = '{valid: lui_r, rep: 1'b0, word: word_r, pos: pos_r};
        emit_want = hit_r && (cnt_r < CntW'(MaxReports));
        advance   = !emit_want || out_free;
        if (advance) begin
          cell_op   = last_r ? CELL_CLEAR : CELL_SHIFT;
          pos_nxt   = last_r ? '0 : pos_r + PositionBits'(1);
          state_nxt = ST_IDLE;
          if (emit_want) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{hit_kind:         kind_r,
                              hit_position:     pos_r,
                              hit_word:         word_r,
                              partner_position: '0,
                              partner_word:     '0,
                              final_report:     1'b1};
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      pos_r       <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    hit_r      <= hit_nxt;
    kind_r     <= kind_nxt;
    last_r     <= last_nxt;
    lui_r      <= lui_nxt;
    out_data_r <= out_data_nxt;
  end

`include "assert_macros.svh"

  `MARS_ASSERT_NOW(a_idle_no_flags, state_r == ST_IDLE, !(rep_rest || oldest.rep), "pair flag left while idle")
  `MARS_ASSERT_NOW(a_rotation_drained, state_r == ST_FINISH, !(rep_rest || oldest.rep), "rotation ended with pair flags set")
  `MARS_ASSERT_NEXT(a_pos_holds, state_r == ST_ROTATE, $stable(pos_r), "word position moved during rotation")

endmodule

`default_nettype wire

### hdl/mars_cell.sv
// ----------------------------------------------------------------------------
// mars_cell
// One pending LUI slot: compares its rt against the probe and moves its
// contents to the next slot on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mars_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  mars_pkg::mars_cell_op_t op_i,
  input  mars_pkg::mars_probe_t   probe_i,
  input  mars_pkg::mars_entry_t   prev_i,
  output mars_pkg::mars_entry_t   fwd_o,
  output logic                    pair_o
);
  import mars_pkg::*;

  logic                    valid_r, valid_nxt;
  logic                    rep_r, rep_nxt;
  logic [31:0]             word_r, word_nxt;
  logic [PositionBits-1:0] pos_r, pos_nxt;
  logic                    match;

  assign match  = probe_i.scan && valid_r && (word_r[20:16] == probe_i.rs);
  assign pair_o = match && probe_i.imm_ok;

  // a slot hit by the probe leaves retired
  assign fwd_o = '{valid: valid_r && !match, rep: rep_r, word: word_r, pos: pos_r};

  always_comb begin
    valid_nxt = valid_r;
    rep_nxt   = rep_r;
    word_nxt  = word_r;
    pos_nxt   = pos_r;
    case (op_i)
      CELL_HOLD: begin
      end
      CELL_RETIRE: begin
        valid_nxt = valid_r && !match;
        rep_nxt   = pair_o;
      end
      CELL_SHIFT: begin
        valid_nxt = prev_i.valid;
        rep_nxt   = prev_i.rep;
        word_nxt  = prev_i.word;
        pos_nxt   = prev_i.pos;
      end
      CELL_CLEAR: begin
        valid_nxt = 1'b0;
        rep_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rep_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rep_r   <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pos_r  <= pos_nxt;
  end

endmodule

`default_nettype wire

### hdl/mars_chain.sv
// ----------------------------------------------------------------------------
// mars_chain
// Row of pending LUI cells, youngest at index 0. Shifts for aging and
// rotates end-around to bring every flagged pair past the oldest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mars_chain #(
  parameter int unsigned PAIR_WINDOW = mars_pkg::PairWindowDef
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  mars_pkg::mars_cell_op_t op_i,
  input  mars_pkg::mars_probe_t   probe_i,
  input  wire                     wrap_i,
  input  mars_pkg::mars_entry_t   head_i,
  output mars_pkg::mars_entry_t   oldest_o,
  output logic                    any_pair_o,
  output logic                    rep_rest_o
);
  import mars_pkg::*;

  mars_entry_t            fwd [PAIR_WINDOW];
  mars_entry_t            head_sel;
  logic [PAIR_WINDOW-1:0] pair_v;

  always_comb begin
    head_sel = head_i;
    if (wrap_i) begin
      head_sel     = fwd[PAIR_WINDOW-1];
      head_sel.rep = 1'b0;
    end
  end

  for (genvar k = 0; k < PAIR_WINDOW; k++) begin : g_cell
    mars_entry_t prev;
    if (k == 0) begin : g_head
      assign prev = head_sel;
    end else begin : g_link
      assign prev = fwd[k-1];
    end
    mars_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op_i    (op_i),
      .probe_i (probe_i),
      .prev_i  (prev),
      .fwd_o   (fwd[k]),
      .pair_o  (pair_v[k])
    );
  end

  assign oldest_o   = fwd[PAIR_WINDOW-1];
  assign any_pair_o = |pair_v;

  // flags still waiting behind the oldest slot
  always_comb begin
    rep_rest_o = 1'b0;
    for (int k = 0; k < PAIR_WINDOW - 1; k++) begin
      rep_rest_o = rep_rest_o | fwd[k].rep;
    end
  end

endmodule

`default_nettype wire

### tb/mips_address_reference_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mips_address_reference_scanner_tb
// Drives word streams into the address reference scanner, predicts every
// direct, JAL and LUI/ADDIU report from a behavioral copy of the pending-LUI
// window, and checks each output beat in order under random idling and stall.
// ----------------------------------------------------------------------------
module mips_address_reference_scanner_tb;
  import mars_pkg::*;

  localparam int PAIR_SLOTS    = PairWindowDef;
  localparam int SETTLE_CYCLES = 2 * (PairWindowDef + 2) + 10;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mars_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mars_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  mips_address_reference_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // scanner copy: target, position and the pending-LUI window
  logic [31:0]             model_target = '0;
  logic [PositionBits-1:0] scan_pos = '0;
  bit                      slot_live [PAIR_SLOTS];
  logic [31:0]             slot_word [PAIR_SLOTS];
  logic [PositionBits-1:0] slot_pos  [PAIR_SLOTS];
  mars_out_t               awaited_hits [$];
  mars_out_t               held_hit;
  bit                      hit_held = 1'b0;

  logic [31:0] stim_target = '0;
  int          burst_left = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          long_hold_req = 1'b0;

  function automatic logic [31:0] jal_of(logic [31:0] addr);
    return {OpJal, addr[27:2]};
  endfunction

  // high half with the carry from bit 15; bit 16 set means no LUI can match
  function automatic logic [16:0] hi_of(logic [31:0] addr);
    return {1'b0, addr[31:16]} + {16'b0, addr[15]};
  endfunction

  function automatic logic [15:0] hi16_of(logic [31:0] addr);
    logic [16:0] h;
    h = hi_of(addr);
    return h[15:0];
  endfunction

  function automatic logic [31:0] lui_insn(logic [4:0] rs, logic [4:0] rt, logic [15:0] imm);
    return {OpLui, rs, rt, imm};
  endfunction

  function automatic logic [31:0] addiu_insn(logic [4:0] rs, logic [4:0] rt,
                                             logic [15:0] imm);
    return {OpAddiu, rs, rt, imm};
  endfunction

  // hold one report back so the last one of a word can be flagged
  function automatic void stage_hit(mars_kind_t kind, logic [PositionBits-1:0] p,
                                    logic [31:0] w, logic [PositionBits-1:0] pp,
                                    logic [31:0] pw);
    if (hit_held) awaited_hits.push_back(held_hit);
    held_hit = '{hit_kind: kind, hit_position: p, hit_word: w, partner_position: pp,
                 partner_word: pw, final_report: 1'b0};
    hit_held = 1'b1;
  endfunction

  function automatic void predict_hits(mars_in_t item);
    logic [31:0]             w;
    logic [PositionBits-1:0] pos;
    bit                      take_lui;
    int                      k;
    w = item.code_word;
    pos = scan_pos;
    take_lui = 1'b0;
    if (w[31:26] == OpAddiu) begin
      // oldest slot first
      for (k = PAIR_SLOTS - 1; k >= 0; k--) begin
        if (slot_live[k] && slot_word[k][20:16] == w[25:21]) begin
          slot_live[k] = 1'b0;
          if (w[15:0] == model_target[15:0])
            stage_hit(HIT_PAIR, slot_pos[k], slot_word[k], pos, w);
        end
      end
    end
    if (w == model_target) begin
      stage_hit(HIT_DIRECT, pos, w, '0, '0);
    end else if (w == jal_of(model_target)) begin
      stage_hit(HIT_JAL, pos, w, '0, '0);
    end else if (w[31:26] == OpLui && {1'b0, w[15:0]} == hi_of(model_target)) begin
      take_lui = 1'b1;
    end
    if (hit_held) begin
      held_hit.final_report = 1'b1;
      awaited_hits.push_back(held_hit);
      hit_held = 1'b0;
    end
    if (item.image_end) begin
      for (k = 0; k < PAIR_SLOTS; k++) slot_live[k] = 1'b0;
      scan_pos = '0;
    end else begin
      for (k = PAIR_SLOTS - 1; k > 0; k--) begin
        slot_live[k] = slot_live[k-1];
        slot_word[k] = slot_word[k-1];
        slot_pos[k]  = slot_pos[k-1];
      end
      slot_live[0] = take_lui;
      slot_word[0] = w;
      slot_pos[0]  = pos;
      scan_pos = pos + PositionBits'(1);
    end
  endfunction

  function automatic void note_failure(string what, mars_out_t exp_hit, mars_out_t got_hit);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t %s: exp kind=%0d pos=%0d word=%h ppos=%0d pword=%h fin=%0b | got kind=%0d pos=%0d word=%h ppos=%0d pword=%h fin=%0b",
               $realtime, what, exp_hit.hit_kind, exp_hit.hit_position, exp_hit.hit_word,
               exp_hit.partner_position, exp_hit.partner_word, exp_hit.final_report,
               got_hit.hit_kind, got_hit.hit_position, got_hit.hit_word,
               got_hit.partner_position, got_hit.partner_word, got_hit.final_report);
  endfunction

  // predict on every accepted word, check every accepted report beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) model_target = cfg_data;
      if (in_valid && !in_stall) predict_hits(in_data);
      if (out_valid && !out_stall) begin
        if (awaited_hits.size() == 0) begin
          note_failure("unexpected beat", '0, out_data);
        end else begin
          if (out_data !== awaited_hits[0]) note_failure("mismatch", awaited_hits[0], out_data);
          void'(awaited_hits.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[mips_address_reference_scanner] ERROR");
      $finish;
    end
  end

  // receiver: random stall stretches, some clean, one long hold on request
  initial begin : stall_pattern
    int run_len;
    int stall_pct;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 75);
        run_len = $urandom_range(4, 40);
        while (run_len > 0 && !long_hold_req) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
          run_len--;
        end
      end
    end
  end

  task automatic send_word(logic [31:0] w, logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{code_word: w, image_end: last};
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain, let any silent retire finish, then write the target
  task automatic retarget(logic [31:0] addr);
    in_valid <= 1'b0;
    while (awaited_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    stim_target = addr;
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_target();
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(jal_of(32'h0), 1'b0);
    send_word(lui_insn(5'd0, 5'd5, 16'h0000), 1'b0);
    send_word(addiu_insn(5'd5, 5'd5, 16'h0000), 1'b0);
    send_word(32'h0000_0000, 1'b1);
  endtask

  task automatic test_hits_and_pairs();
    logic [15:0] hi;
    logic [15:0] lo;
    retarget(32'h8024_5678);
    hi = hi16_of(stim_target);
    lo = stim_target[15:0];
    send_word(stim_target, 1'b0);
    send_word(jal_of(stim_target), 1'b0);
    send_word(lui_insn(5'd0, 5'd3, hi), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(addiu_insn(5'd3, 5'd9, lo), 1'b0);
    // wrong immediate retires silently, a later good one finds nothing
    send_word(lui_insn(5'd0, 5'd7, hi), 1'b0);
    send_word(addiu_insn(5'd7, 5'd7, ~lo), 1'b0);
    send_word(addiu_insn(5'd7, 5'd0, lo), 1'b0);
    send_word(lui_insn(5'd1, 5'd2, hi), 1'b0);
    send_word(lui_insn(5'd2, 5'd2, hi), 1'b0);
    send_word(addiu_insn(5'd2, 5'd2, lo), 1'b0);
    send_word(lui_insn(5'd0, 5'd5, hi ^ 16'h0001), 1'b0);
    send_word(addiu_insn(5'd5, 5'd0, lo), 1'b0);
    // an LUI in the final word is dropped
    send_word(lui_insn(5'd0, 5'd6, hi), 1'b1);
    send_word(addiu_insn(5'd6, 5'd0, lo), 1'b0);
    send_word(lui_insn(5'd0, 5'd1, hi), 1'b0);
    send_word(addiu_insn(5'd1, 5'd1, lo), 1'b1);
  endtask

  task automatic test_high_half_carry();
    retarget(32'h1234_9ABC);
    send_word(lui_insn(5'd0, 5'd9, 16'h1234), 1'b0);
    send_word(lui_insn(5'd0, 5'd9, 16'h1235), 1'b0);
    send_word(addiu_insn(5'd9, 5'd9, 16'h9ABC), 1'b1);
    // carry out of the high half: no LUI is ever held
    retarget(32'hFFFF_8001);
    send_word(lui_insn(5'd0, 5'd1, 16'hFFFF), 1'b0);
    send_word(lui_insn(5'd0, 5'd1, 16'h0000), 1'b0);
    send_word(addiu_insn(5'd1, 5'd1, 16'h8001), 1'b0);
    send_word(jal_of(stim_target), 1'b1);
  endtask

  task automatic test_hit_word_forms();
    // target that is itself a matching LUI: reported, not held
    retarget(32'h3C04_3C04);
    send_word(stim_target, 1'b0);
    send_word(addiu_insn(5'd4, 5'd4, 16'h3C04), 1'b0);
    send_word(lui_insn(5'd1, 5'd4, 16'h3C04), 1'b0);
    send_word(addiu_insn(5'd4, 5'd4, 16'h3C04), 1'b1);
    // target that is an ADDIU: pairs first, then the direct hit
    retarget(32'h2484_1234);
    send_word(lui_insn(5'd0, 5'd4, 16'h2484), 1'b0);
    send_word(stim_target, 1'b1);
  endtask

  task automatic test_full_window();
    int i;
    retarget(32'h2484_1234);
    // every slot pairs with one word that is also a direct hit
    for (i = 0; i < PAIR_SLOTS; i++) send_word(lui_insn(5'(i), 5'd4, 16'h2484), 1'b0);
    send_word(stim_target, 1'b0);
    // oldest slot still pairs, one word later it has aged out
    send_word(lui_insn(5'd0, 5'd6, 16'h2484), 1'b0);
    for (i = 0; i < PAIR_SLOTS - 1; i++) send_word(32'h0000_0000, 1'b0);
    send_word(addiu_insn(5'd6, 5'd0, 16'h1234), 1'b0);
    send_word(lui_insn(5'd0, 5'd6, 16'h2484), 1'b0);
    for (i = 0; i < PAIR_SLOTS; i++) send_word(32'h0000_0000, 1'b0);
    send_word(addiu_insn(5'd6, 5'd0, 16'h1234), 1'b1);
  endtask

  task automatic test_extreme_target();
    retarget(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(jal_of(stim_target), 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(lui_insn(5'd31, 5'd31, 16'hFFFF), 1'b0);
    send_word(addiu_insn(5'd31, 5'd31, 16'hFFFF), 1'b1);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                         5'($urandom_range(1, 3));
  endfunction

  task automatic send_random_image(int count);
    int          i;
    int          roll;
    logic [31:0] w;
    logic [15:0] hi;
    for (i = 0; i < count; i++) begin
      hi = hi16_of(stim_target);
      roll = $urandom_range(0, 99);
      if (roll < 12)      w = $urandom;
      else if (roll < 20) w = stim_target;
      else if (roll < 27) w = jal_of(stim_target);
      else if (roll < 50) w = lui_insn(5'($urandom_range(0, 31)), pick_reg(), hi);
      else if (roll < 75)
        w = addiu_insn(pick_reg(), 5'($urandom_range(0, 31)),
                       ($urandom_range(0, 3) != 0) ? stim_target[15:0] : 16'($urandom));
      else if (roll < 85)
        w = lui_insn(5'($urandom_range(0, 31)), pick_reg(), 16'($urandom));
      else begin
        w = $urandom;
        case ($urandom_range(0, 2))
          0:       w[31:26] = OpAddiu;
          1:       w[31:26] = OpLui;
          default: w[31:26] = OpJal;
        endcase
      end
      send_word(w, (i == count - 1) || ($urandom_range(0, 49) == 0));
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    retarget($urandom);
    long_hold_req = 1'b1;
    for (i = 0; i < 40; i++) begin
      case (i % 4)
        0: send_word(stim_target, 1'b0);
        1: send_word(lui_insn(5'd0, 5'd1, hi16_of(stim_target)), 1'b0);
        2: send_word(addiu_insn(5'd1, 5'd1, stim_target[15:0]), 1'b0);
        default: send_word(jal_of(stim_target), i == 39);
      endcase
    end
  endtask

  task automatic test_random_images();
    int          p;
    logic [31:0] t;
    for (p = 0; p < 6; p++) begin
      t = $urandom;
      case (p)
        0: t[15] = 1'b1;
        1: t[15] = 1'b0;
        2: t[31:15] = 17'h1FFFF;
        3: t[31:26] = OpAddiu;
        4: t = '0;
        default: ;
      endcase
      retarget(t);
      send_random_image(30);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_target();
    test_hits_and_pairs();
    test_high_half_carry();
    test_hit_word_forms();
    test_full_window();
    test_extreme_target();
    test_output_backpressure();
    test_random_images();
    in_valid <= 1'b0;
    while (awaited_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[mips_address_reference_scanner] OK");
    else
      $display("[mips_address_reference_scanner] ERROR");
    $finish;
  end

endmodule
